/* design/prws_pkg.sv */
// Shared constants, types and helper functions for the random-walk step unit.
// Depends on nothing; imported by particle_random_walk_step_unit.
`default_nettype none

package prws_pkg;

  // Fixed-point formats
  localparam int ANGLE_BITS = 16;   // binary angle, full turn = 2^ANGLE_BITS
  localparam int FRAC_BITS  = 16;   // fraction bits of position and speed

  // Field widths
  localparam int POS_W  = 32;
  localparam int SPD_W  = 24;
  localparam int HDG_W  = 16;
  localparam int RND_W  = 16;
  localparam int GAIN_W = 16;
  localparam int MODE_W = 2;
  localparam int TRIG_W = 18;       // signed Q1.15 with room for +1.0

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ENGINE_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRIC_ENABLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRIC_QUAD     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRIC_RATE     = 3'd6;

  localparam logic [MODE_W-1:0] MODE_KINEMATIC = 2'd0;

  // Register reset values
  localparam logic [MODE_W-1:0] RST_ENGINE_MODE   = 2'd0;
  localparam logic [GAIN_W-1:0] RST_TIME_STEP     = 16'd1092;
  localparam logic [GAIN_W-1:0] RST_ACCEL_GAIN    = 16'd655;
  localparam logic [GAIN_W-1:0] RST_TURN_GAIN     = 16'd1024;
  localparam logic [GAIN_W-1:0] RST_FRIC_RATE     = 16'd655;

  // Rescaling shifts
  localparam int SPD_SHIFT  = 31 - FRAC_BITS;
  localparam int TURN_SHIFT = 15;
  localparam int LIN_SHIFT  = 16;
  localparam int QUAD_SHIFT = 16 + FRAC_BITS;
  localparam int POS_SHIFT  = 31;

  // Quarter-wave sine polynomial coefficients (Q16)
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42048;
  localparam logic [12:0] SIN_C = 13'd4640;
  localparam logic [15:0] Z_MAX = 16'd32768;

  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = {2'b01, {(ANGLE_BITS-2){1'b0}}};

  localparam logic signed [63:0] SPD_MAX = (64'sd1 <<< (SPD_W-1)) - 64'sd1;
  localparam logic signed [63:0] SPD_MIN = -SPD_MAX - 64'sd1;
  localparam logic signed [63:0] POS_MAX = (64'sd1 <<< (POS_W-1)) - 64'sd1;
  localparam logic signed [63:0] POS_MIN = -POS_MAX - 64'sd1;

  // Reduced angle: polynomial argument in [0, 32768] and output sign
  typedef struct packed {
    logic        neg;
    logic [15:0] z;
  } angle_t;

  // Split a binary angle into quadrant and reflected Q15 argument
  function automatic angle_t angle_prep(input logic [ANGLE_BITS-1:0] h);
    logic [ANGLE_BITS+16:0] ext;
    logic [16:0]            v17;
    angle_t                 a;
    ext   = {h, 17'b0};
    v17   = ext[ANGLE_BITS+16:ANGLE_BITS];
    a.neg = v17[16];
    a.z   = v17[15] ? (Z_MAX - {1'b0, v17[14:0]}) : {1'b0, v17[14:0]};
    return a;
  endfunction

  function automatic logic signed [SPD_W-1:0] sat_spd(input logic signed [63:0] v);
    if (v > SPD_MAX) return SPD_MAX[SPD_W-1:0];
    if (v < SPD_MIN) return SPD_MIN[SPD_W-1:0];
    return v[SPD_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] v);
    if (v > POS_MAX) return POS_MAX[POS_W-1:0];
    if (v < POS_MIN) return POS_MIN[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/particle_random_walk_step_unit.sv */
// Random-walk step unit: eight-stage pipeline that moves one polar particle.
// Depends on prws_pkg (formats, coefficients, saturation and angle helpers).
//
// Usage:
//   Input channel in_*: one particle per request (position, speed, heading and
//   two random values), taken when in_valid and in_ready are both high.
//   Output channel out_*: the updated particle, taken on out_valid && out_ready.
//   Configuration port cfg_*: write cfg_wdata to register cfg_index whenever
//   cfg_we is high; indexes past the last register are ignored. Write only
//   while the pipeline is empty.
// Pipeline: a request taken on in_* passes through eight register stages, the
//   input register being the first, before it shows on out_*.
// Throughput: one request per cycle while out_ready is high. The depth comes from the sine
//   polynomial, whose four dependent multiplies each get a stage, followed
//   by the two multiplies of the position step.
// Reset (synchronous, rst_n low): all stage valid bits clear and the
//   registers take their default values; payload registers are not reset.
// Stall: when out_ready is low the last stage holds; each stage still takes
//   new data while the stage after it is empty or moving, so bubbles
//   collapse and in_ready drops only once every stage is full.
`default_nettype none

module particle_random_walk_step_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [prws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [prws_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input requests
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [prws_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [prws_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [prws_pkg::SPD_W-1:0]   in_speed_in,
  input  logic        [prws_pkg::HDG_W-1:0]   in_heading_in,
  input  logic signed [prws_pkg::RND_W-1:0]   in_rand_speed,
  input  logic signed [prws_pkg::RND_W-1:0]   in_rand_turn,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [prws_pkg::POS_W-1:0]   out_new_x,
  output logic signed [prws_pkg::POS_W-1:0]   out_new_y,
  output logic signed [prws_pkg::SPD_W-1:0]   out_new_speed,
  output logic        [prws_pkg::HDG_W-1:0]   out_new_heading
);
  import prws_pkg::*;

  localparam int STAGES = 8;
  localparam int AXES   = 2;   // lane 0: x / cosine, lane 1: y / sine

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [MODE_W-1:0] engine_mode_r;
  logic [GAIN_W-1:0] time_step_r;
  logic [GAIN_W-1:0] accel_gain_r;
  logic [GAIN_W-1:0] turn_gain_r;
  logic              friction_enable_r;
  logic              friction_quadratic_r;
  logic [GAIN_W-1:0] friction_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      engine_mode_r        <= RST_ENGINE_MODE;
      time_step_r          <= RST_TIME_STEP;
      accel_gain_r         <= RST_ACCEL_GAIN;
      turn_gain_r          <= RST_TURN_GAIN;
      friction_enable_r    <= 1'b0;
      friction_quadratic_r <= 1'b0;
      friction_rate_r      <= RST_FRIC_RATE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENGINE_MODE: engine_mode_r        <= cfg_wdata[MODE_W-1:0];
        REG_TIME_STEP:   time_step_r          <= cfg_wdata[GAIN_W-1:0];
        REG_ACCEL_GAIN:  accel_gain_r         <= cfg_wdata[GAIN_W-1:0];
        REG_TURN_GAIN:   turn_gain_r          <= cfg_wdata[GAIN_W-1:0];
        REG_FRIC_ENABLE: friction_enable_r    <= cfg_wdata[0];
        REG_FRIC_QUAD:   friction_quadratic_r <= cfg_wdata[0];
        REG_FRIC_RATE:   friction_rate_r      <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic kinematic;
  assign kinematic = (engine_mode_r == MODE_KINEMATIC);

  // ---------------------------------------------------------------------
  // Stage valid bits and per-stage advance
  logic [STAGES:1]   vld_r;
  logic [STAGES+1:1] adv;

  always_comb begin
    adv[STAGES+1] = out_ready;
    for (int k = STAGES; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= STAGES; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = vld_r[STAGES];

  // ---------------------------------------------------------------------
  // Stage 1: capture request, reduce angles, random-step products
  logic [31:0]             hd_in_ext;
  logic [ANGLE_BITS-1:0]   hd_in;
  angle_t                  s1_ang_nxt [AXES];
  logic signed [32:0]      s1_sprod_nxt, s1_tprod_nxt;

  logic signed [POS_W-1:0] s1_pos_r [AXES];
  logic signed [SPD_W-1:0] s1_spd_r;
  logic [ANGLE_BITS-1:0]   s1_hd_r;
  angle_t                  s1_ang_r [AXES];
  logic signed [32:0]      s1_sprod_r, s1_tprod_r;

  assign hd_in_ext     = 32'(in_heading_in);
  assign hd_in         = hd_in_ext[ANGLE_BITS-1:0];
  assign s1_ang_nxt[0] = angle_prep(hd_in + QUARTER_TURN);
  assign s1_ang_nxt[1] = angle_prep(hd_in);
  assign s1_sprod_nxt  = in_rand_speed * signed'({1'b0, accel_gain_r});
  assign s1_tprod_nxt  = in_rand_turn * signed'({1'b0, turn_gain_r});

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_pos_r[0] <= in_pos_x;
      s1_pos_r[1] <= in_pos_y;
      s1_spd_r    <= in_speed_in;
      s1_hd_r     <= hd_in;
      s1_ang_r    <= s1_ang_nxt;
      s1_sprod_r  <= s1_sprod_nxt;
      s1_tprod_r  <= s1_tprod_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: z^2, speed and heading random step
  logic [31:0]             zz [AXES];
  logic [15:0]             s2_z2_nxt [AXES];
  logic signed [32:0]      dturn;
  logic signed [SPD_W-1:0] s2_spd1_nxt;
  logic [ANGLE_BITS-1:0]   s2_hd_nxt;

  logic signed [POS_W-1:0] s2_pos_r [AXES];
  logic signed [SPD_W-1:0] s2_spd0_r, s2_spd1_r;
  logic [ANGLE_BITS-1:0]   s2_hd_r;
  angle_t                  s2_ang_r [AXES];
  logic [15:0]             s2_z2_r [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      zz[i]        = s1_ang_r[i].z * s1_ang_r[i].z;
      s2_z2_nxt[i] = zz[i][30:15];
    end
    dturn       = s1_tprod_r >>> TURN_SHIFT;
    s2_spd1_nxt = kinematic ? sat_spd(64'(s1_spd_r) + 64'(s1_sprod_r >>> SPD_SHIFT))
                            : s1_spd_r;
    s2_hd_nxt   = kinematic ? (s1_hd_r + dturn[ANGLE_BITS-1:0]) : s1_hd_r;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_pos_r  <= s1_pos_r;
      s2_spd0_r <= s1_spd_r;
      s2_spd1_r <= s2_spd1_nxt;
      s2_hd_r   <= s2_hd_nxt;
      s2_ang_r  <= s1_ang_r;
      s2_z2_r   <= s2_z2_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: B - z^2*C; friction products (linear, speed squared)
  logic [28:0]             c_prod [AXES];
  logic [15:0]             s3_t2_nxt [AXES];
  logic [SPD_W-1:0]        mag;
  logic [2*SPD_W-1:0]      s3_sq_nxt;
  logic signed [40:0]      s3_lin_nxt;

  logic signed [POS_W-1:0] s3_pos_r [AXES];
  logic signed [SPD_W-1:0] s3_spd0_r, s3_spd1_r;
  logic [ANGLE_BITS-1:0]   s3_hd_r;
  angle_t                  s3_ang_r [AXES];
  logic [15:0]             s3_z2_r [AXES];
  logic [15:0]             s3_t2_r [AXES];
  logic [2*SPD_W-1:0]      s3_sq_r;
  logic signed [40:0]      s3_lin_r;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      c_prod[i]    = s2_z2_r[i] * SIN_C;
      s3_t2_nxt[i] = SIN_B - {3'b0, c_prod[i][27:15]};
    end
    mag        = s2_spd1_r[SPD_W-1] ? SPD_W'(-s2_spd1_r) : SPD_W'(s2_spd1_r);
    s3_sq_nxt  = mag * mag;
    s3_lin_nxt = signed'({1'b0, friction_rate_r}) * s2_spd1_r;
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_pos_r  <= s2_pos_r;
      s3_spd0_r <= s2_spd0_r;
      s3_spd1_r <= s2_spd1_r;
      s3_hd_r   <= s2_hd_r;
      s3_ang_r  <= s2_ang_r;
      s3_z2_r   <= s2_z2_r;
      s3_t2_r   <= s3_t2_nxt;
      s3_sq_r   <= s3_sq_nxt;
      s3_lin_r  <= s3_lin_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: A - z^2*(...); quadratic friction partial products, linear result
  logic [31:0]             t3_prod [AXES];
  logic [16:0]             s4_t4_nxt [AXES];
  logic [47:0]             s4_phi_nxt;
  logic [31:0]             s4_plo_nxt;
  logic signed [SPD_W-1:0] s4_lin_nxt;

  logic signed [POS_W-1:0] s4_pos_r [AXES];
  logic signed [SPD_W-1:0] s4_spd0_r, s4_spd1_r, s4_lin_r;
  logic [ANGLE_BITS-1:0]   s4_hd_r;
  angle_t                  s4_ang_r [AXES];
  logic [16:0]             s4_t4_r [AXES];
  logic [47:0]             s4_phi_r;
  logic [31:0]             s4_plo_r;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      t3_prod[i]   = s3_z2_r[i] * s3_t2_r[i];
      s4_t4_nxt[i] = SIN_A - {1'b0, t3_prod[i][30:15]};
    end
    s4_phi_nxt = s3_sq_r[2*SPD_W-1:16] * friction_rate_r;
    s4_plo_nxt = s3_sq_r[15:0] * friction_rate_r;
    s4_lin_nxt = sat_spd(64'(s3_spd1_r) - 64'(s3_lin_r >>> LIN_SHIFT));
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_pos_r  <= s3_pos_r;
      s4_spd0_r <= s3_spd0_r;
      s4_spd1_r <= s3_spd1_r;
      s4_hd_r   <= s3_hd_r;
      s4_ang_r  <= s3_ang_r;
      s4_t4_r   <= s4_t4_nxt;
      s4_phi_r  <= s4_phi_nxt;
      s4_plo_r  <= s4_plo_nxt;
      s4_lin_r  <= s4_lin_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: finish sine/cosine; select friction result
  logic [32:0]              sp [AXES];
  logic signed [TRIG_W-1:0] trig_mag [AXES];
  logic signed [TRIG_W-1:0] s5_trig_nxt [AXES];
  logic [63:0]              fr_total, fr_m;
  logic signed [SPD_W-1:0]  s5_spd_nxt;

  logic signed [POS_W-1:0]  s5_pos_r [AXES];
  logic signed [SPD_W-1:0]  s5_spd0_r, s5_spd_r;
  logic [ANGLE_BITS-1:0]    s5_hd_r;
  logic signed [TRIG_W-1:0] s5_trig_r [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      sp[i]          = s4_ang_r[i].z * s4_t4_r[i];
      trig_mag[i]    = signed'({1'b0, sp[i][32:16]});
      s5_trig_nxt[i] = s4_ang_r[i].neg ? -trig_mag[i] : trig_mag[i];
    end
    fr_total = {s4_phi_r, 16'b0} + {32'b0, s4_plo_r};
    fr_m     = fr_total >> QUAD_SHIFT;
    // quadratic friction pushes toward zero, zero speed stays put
    priority if (!friction_enable_r) begin
      s5_spd_nxt = s4_spd1_r;
    end else if (!friction_quadratic_r) begin
      s5_spd_nxt = s4_lin_r;
    end else if (s4_spd1_r > 0) begin
      s5_spd_nxt = sat_spd(64'(s4_spd1_r) - signed'(fr_m));
    end else if (s4_spd1_r < 0) begin
      s5_spd_nxt = sat_spd(64'(s4_spd1_r) + signed'(fr_m));
    end else begin
      s5_spd_nxt = s4_spd1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_pos_r  <= s4_pos_r;
      s5_spd0_r <= s4_spd0_r;
      s5_spd_r  <= s5_spd_nxt;
      s5_hd_r   <= s4_hd_r;
      s5_trig_r <= s5_trig_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: trig * time step
  logic signed [34:0]      s6_td_nxt [AXES];

  logic signed [POS_W-1:0] s6_pos_r [AXES];
  logic signed [SPD_W-1:0] s6_spd0_r, s6_spd_r;
  logic [ANGLE_BITS-1:0]   s6_hd_r;
  logic signed [34:0]      s6_td_r [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      s6_td_nxt[i] = s5_trig_r[i] * signed'({1'b0, time_step_r});
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_pos_r  <= s5_pos_r;
      s6_spd0_r <= s5_spd0_r;
      s6_spd_r  <= s5_spd_r;
      s6_hd_r   <= s5_hd_r;
      s6_td_r   <= s6_td_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: speed * (trig * dt), split into low and high partial products
  logic signed [40:0]      s7_lo_nxt [AXES];
  logic signed [42:0]      s7_hi_nxt [AXES];

  logic signed [POS_W-1:0] s7_pos_r [AXES];
  logic signed [SPD_W-1:0] s7_spd_r;
  logic [ANGLE_BITS-1:0]   s7_hd_r;
  logic signed [40:0]      s7_lo_r [AXES];
  logic signed [42:0]      s7_hi_r [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      s7_lo_nxt[i] = s6_spd0_r * signed'({1'b0, s6_td_r[i][15:0]});
      s7_hi_nxt[i] = s6_spd0_r * signed'(s6_td_r[i][34:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_pos_r <= s6_pos_r;
      s7_spd_r <= s6_spd_r;
      s7_hd_r  <= s6_hd_r;
      s7_lo_r  <= s7_lo_nxt;
      s7_hi_r  <= s7_hi_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 8: sum partials, floor shift, add to position, saturate
  logic signed [63:0]      step [AXES];
  logic signed [POS_W-1:0] s8_pos_nxt [AXES];

  logic signed [POS_W-1:0] s8_pos_r [AXES];
  logic signed [SPD_W-1:0] s8_spd_r;
  logic [ANGLE_BITS-1:0]   s8_hd_r;
  logic [31:0]             hd_out_ext;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      step[i]       = ((64'(s7_hi_r[i]) <<< 16) + 64'(s7_lo_r[i])) >>> POS_SHIFT;
      s8_pos_nxt[i] = kinematic ? sat_pos(64'(s7_pos_r[i]) + step[i]) : s7_pos_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s8_pos_r <= s8_pos_nxt;
      s8_spd_r <= s7_spd_r;
      s8_hd_r  <= s7_hd_r;
    end
  end

  assign hd_out_ext      = 32'(s8_hd_r);
  assign out_new_x       = s8_pos_r[0];
  assign out_new_y       = s8_pos_r[1];
  assign out_new_speed   = s8_spd_r;
  assign out_new_heading = hd_out_ext[HDG_W-1:0];

  // ---------------------------------------------------------------------
  // Assertions
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r && !out_ready) |-> !in_ready)
    else $error("pipeline full and stalled but input still ready");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[1])
    else $error("accepted request missing from first stage");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && adv[2]) |=> vld_r[2])
    else $error("request lost between first and second stage");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !vld_r[STAGES-1]) |=> !out_valid)
    else $error("result repeated after delivery");

endmodule

`default_nettype wire

/* tb/tb_particle_random_walk_step_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for particle_random_walk_step_unit: corner particles,
// register corner cases and randomized walks, with random gaps and output stalls.
// Depends on prws_pkg and the unit's RTL.

module tb_particle_random_walk_step_unit;
  import prws_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED       = 3'd7;
  localparam logic [MODE_W-1:0]    MODE_DYNAMIC     = 2'd1;
  localparam logic [MODE_W-1:0]    MODE_DYNAMIC_ALT = 2'd2;
  localparam logic [MODE_W-1:0]    MODE_UNUSED      = 2'd3;

  localparam logic signed [POS_W-1:0] POS_TOP    = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_BOTTOM = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [SPD_W-1:0] SPD_TOP    = {1'b0, {(SPD_W-1){1'b1}}};
  localparam logic signed [SPD_W-1:0] SPD_BOTTOM = {1'b1, {(SPD_W-1){1'b0}}};
  localparam logic signed [RND_W-1:0] RND_TOP    = {1'b0, {(RND_W-1){1'b1}}};
  localparam logic signed [RND_W-1:0] RND_BOTTOM = {1'b1, {(RND_W-1){1'b0}}};

  localparam int PIPE_SLACK   = 16;       // pipeline depth plus margin
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;
  localparam int WALK_PHASES  = 15;
  localparam int WALK_ITEMS   = 100;
  localparam int GAIN_ITEMS   = 80;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [SPD_W-1:0] speed;
    logic        [HDG_W-1:0] heading;
    logic signed [RND_W-1:0] rand_speed;
    logic signed [RND_W-1:0] rand_turn;
  } particle_t;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [SPD_W-1:0] speed;
    logic        [HDG_W-1:0] heading;
  } step_t;

  typedef enum {RDY_OPEN, RDY_LIGHT, RDY_HEAVY, RDY_BURSTY} ready_pattern_e;

  // DUT signals
  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index     = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata     = '0;
  logic                    in_valid      = 1'b0;
  logic                    in_ready;
  logic signed [POS_W-1:0] in_pos_x      = '0;
  logic signed [POS_W-1:0] in_pos_y      = '0;
  logic signed [SPD_W-1:0] in_speed_in   = '0;
  logic        [HDG_W-1:0] in_heading_in = '0;
  logic signed [RND_W-1:0] in_rand_speed = '0;
  logic signed [RND_W-1:0] in_rand_turn  = '0;
  logic                    out_valid;
  logic                    out_ready     = 1'b0;
  logic signed [POS_W-1:0] out_new_x;
  logic signed [POS_W-1:0] out_new_y;
  logic signed [SPD_W-1:0] out_new_speed;
  logic        [HDG_W-1:0] out_new_heading;

  // Shadow copy of the register file
  logic [MODE_W-1:0] mode_cfg      = RST_ENGINE_MODE;
  logic [GAIN_W-1:0] dt_cfg        = RST_TIME_STEP;
  logic [GAIN_W-1:0] accel_cfg     = RST_ACCEL_GAIN;
  logic [GAIN_W-1:0] turn_cfg      = RST_TURN_GAIN;
  logic              fric_en_cfg   = 1'b0;
  logic              fric_quad_cfg = 1'b0;
  logic [GAIN_W-1:0] rate_cfg      = RST_FRIC_RATE;

  step_t          pending_steps[$];
  int             fail_count       = 0;
  int             cycle_count      = 0;
  int             burst_left       = 0;
  ready_pattern_e ready_mode       = RDY_OPEN;
  int             ready_phase_left = 0;
  int             stall_run        = 0;

  particle_random_walk_step_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_speed_in     (in_speed_in),
    .in_heading_in   (in_heading_in),
    .in_rand_speed   (in_rand_speed),
    .in_rand_turn    (in_rand_turn),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_new_x       (out_new_x),
    .out_new_y       (out_new_y),
    .out_new_speed   (out_new_speed),
    .out_new_heading (out_new_heading)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Q15 sine of a binary angle: fold to the first quadrant, odd quintic there
  function automatic longint sine_q15(input logic [HDG_W-1:0] angle);
    logic [1:0]      quad;
    longint unsigned z, z2, t1, t3, mag;
    quad = angle[HDG_W-1:HDG_W-2];
    z    = 64'({angle[HDG_W-3:0], 1'b0});
    if (quad[0]) z = 64'd32768 - z;
    z2  = (z * z) >> 15;
    t1  = (z2 * longint'(SIN_C)) >> 15;
    t3  = (z2 * (longint'(SIN_B) - t1)) >> 15;
    mag = (z * (longint'(SIN_A) - t3)) >> 16;
    return quad[1] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clamp_signed(input longint v, input int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Expected particle after one step; signed shifts floor toward minus infinity
  function automatic step_t predict_walk_step(input particle_t p);
    longint           px, py, spd, rs, rt, cs, sn, dt, accel, turn, rate, dturn;
    longint unsigned  mag, drag;
    logic [HDG_W-1:0] hd;
    step_t            r;
    px    = longint'(p.x);
    py    = longint'(p.y);
    spd   = longint'(p.speed);
    hd    = p.heading;
    rs    = longint'(p.rand_speed);
    rt    = longint'(p.rand_turn);
    dt    = longint'(dt_cfg);
    accel = longint'(accel_cfg);
    turn  = longint'(turn_cfg);
    rate  = longint'(rate_cfg);
    if (mode_cfg == MODE_KINEMATIC) begin
      // move with the old speed and heading first
      cs    = sine_q15(hd + QUARTER_TURN);
      sn    = sine_q15(hd);
      px    = clamp_signed(px + ((spd * cs * dt) >>> 31), POS_W);
      py    = clamp_signed(py + ((spd * sn * dt) >>> 31), POS_W);
      spd   = clamp_signed(spd + ((rs * accel) >>> (31 - FRAC_BITS)), SPD_W);
      dturn = (rt * turn) >>> 15;
      hd    = hd + dturn[HDG_W-1:0];
    end
    if (fric_en_cfg) begin
      if (!fric_quad_cfg) begin
        spd = clamp_signed(spd - ((rate * spd) >>> 16), SPD_W);
      end else if (spd != 0) begin
        // may cross zero; only saturated
        mag  = (spd < 0) ? -spd : spd;
        drag = (longint'(rate) * mag * mag) >> (16 + FRAC_BITS);
        spd  = clamp_signed((spd > 0) ? spd - longint'(drag) : spd + longint'(drag), SPD_W);
      end
    end
    r.x       = px[POS_W-1:0];
    r.y       = py[POS_W-1:0];
    r.speed   = spd[SPD_W-1:0];
    r.heading = hd;
    return r;
  endfunction

  function automatic void set_reg_shadow(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ENGINE_MODE: mode_cfg      = data[MODE_W-1:0];
      REG_TIME_STEP:   dt_cfg        = data[GAIN_W-1:0];
      REG_ACCEL_GAIN:  accel_cfg     = data[GAIN_W-1:0];
      REG_TURN_GAIN:   turn_cfg      = data[GAIN_W-1:0];
      REG_FRIC_ENABLE: fric_en_cfg   = data[0];
      REG_FRIC_QUAD:   fric_quad_cfg = data[0];
      REG_FRIC_RATE:   rate_cfg      = data[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic particle_t make_particle(input logic signed [POS_W-1:0] x, y,
                                              input logic signed [SPD_W-1:0] spd,
                                              input logic [HDG_W-1:0] hd,
                                              input logic signed [RND_W-1:0] rs, rt);
    particle_t p;
    p.x          = x;
    p.y          = y;
    p.speed      = spd;
    p.heading    = hd;
    p.rand_speed = rs;
    p.rand_turn  = rt;
    return p;
  endfunction

  function automatic particle_t random_particle();
    particle_t        p;
    logic [RND_W-1:0] low_speed;
    p.x          = $urandom;
    p.y          = $urandom;
    p.speed      = SPD_W'($urandom);
    p.heading    = HDG_W'($urandom);
    p.rand_speed = RND_W'($urandom);
    p.rand_turn  = RND_W'($urandom);
    low_speed    = RND_W'($urandom);
    // pull a field to its limit now and then
    case ($urandom_range(0, 15))
      0: p.x = POS_TOP;
      1: p.x = POS_BOTTOM;
      2: p.y = POS_TOP;
      3: p.y = POS_BOTTOM;
      4: p.speed = SPD_TOP;
      5: p.speed = SPD_BOTTOM;
      6: p.rand_speed = RND_TOP;
      7: p.rand_turn = RND_BOTTOM;
      8, 9: p.speed = {{(SPD_W-RND_W){low_speed[RND_W-1]}}, low_speed};
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    logic [GAIN_W-1:0] g;
    g = GAIN_W'($urandom);
    case ($urandom_range(0, 5))
      0: g = '0;
      1: g = '1;
      default: ;
    endcase
    return g;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_reg_shadow(idx, data);
  endtask

  // Writes every register; narrow ones get junk in the unused upper bits
  task automatic apply_settings(input logic [MODE_W-1:0] mode,
                                input logic [GAIN_W-1:0] dt, accel, turn,
                                input logic fen, fquad,
                                input logic [GAIN_W-1:0] rate);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_ENGINE_MODE, {junk[CFG_DATA_W-1:MODE_W], mode});
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_ACCEL_GAIN, accel);
    write_reg(REG_TURN_GAIN, turn);
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_FRIC_ENABLE, {junk[CFG_DATA_W-1:1], fen});
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_FRIC_QUAD, {junk[CFG_DATA_W-1:1], fquad});
    write_reg(REG_FRIC_RATE, rate);
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_UNUSED, junk);
  endtask

  // One request; bursts of random length separated by random gaps
  task automatic send_particle(input particle_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                : $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_pos_x      <= p.x;
    in_pos_y      <= p.y;
    in_speed_in   <= p.speed;
    in_heading_in <= p.heading;
    in_rand_speed <= p.rand_speed;
    in_rand_turn  <= p.rand_turn;
    do @(posedge clk); while (!in_ready);
    pending_steps.push_back(predict_walk_step(p));
  endtask

  // Drain all results before touching the registers
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // Reset register values; field extremes and heading quadrant edges
  task automatic test_directed_extremes();
    send_particle(make_particle('0, '0, '0, 16'h0000, '0, '0));
    send_particle(make_particle(POS_TOP, POS_TOP, SPD_TOP, 16'h0000, RND_TOP, RND_TOP));
    send_particle(make_particle(POS_BOTTOM, POS_BOTTOM, SPD_BOTTOM, 16'h0000,
                                RND_BOTTOM, RND_BOTTOM));
    send_particle(make_particle('0, '0, SPD_TOP, 16'h4000, '0, '0));
    send_particle(make_particle('0, '0, SPD_TOP, 16'h8000, RND_TOP, RND_BOTTOM));
    send_particle(make_particle('0, '0, SPD_TOP, 16'hC000, RND_BOTTOM, RND_TOP));
    send_particle(make_particle('0, '0, SPD_BOTTOM, 16'hFFFF, '0, '0));
    send_particle(make_particle('0, '0, SPD_TOP, 16'h2000, '0, '0));
    send_particle(make_particle(POS_TOP, POS_BOTTOM, SPD_TOP, 16'hE000, RND_TOP, RND_TOP));
    send_particle(make_particle(-32'sd1, -32'sd1, -24'sd1, 16'h7FFF, -16'sd1, -16'sd1));
    send_particle(make_particle(POS_BOTTOM, POS_TOP, SPD_BOTTOM, 16'h3FFF, '0, RND_TOP));
    settle_pipeline();
  endtask

  // Unused mode, extra register bits, ignored index, friction corners
  task automatic test_register_corners();
    write_reg(REG_ENGINE_MODE, 16'hFFFF);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_particle(make_particle(POS_TOP, POS_BOTTOM, SPD_TOP, 16'h2000, RND_TOP, RND_TOP));
    send_particle(make_particle('0, '0, SPD_BOTTOM, 16'h9000, RND_BOTTOM, RND_BOTTOM));
    settle_pipeline();
    // quadratic friction overshooting zero
    apply_settings(MODE_KINEMATIC, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
    send_particle(make_particle('0, '0, SPD_TOP, 16'h0000, RND_TOP, '0));
    send_particle(make_particle('0, '0, SPD_BOTTOM, 16'h8000, RND_BOTTOM, '0));
    send_particle(make_particle('0, '0, '0, 16'h1000, '0, '0));
    send_particle(make_particle('0, '0, 24'sh000100, 16'h5000, '0, RND_TOP));
    settle_pipeline();
    apply_settings(MODE_DYNAMIC, '0, '0, '0, 1'b1, 1'b0, 16'hFFFF);
    send_particle(make_particle(POS_TOP, POS_TOP, SPD_TOP, 16'h1234, RND_TOP, RND_TOP));
    send_particle(make_particle(POS_BOTTOM, '0, SPD_BOTTOM, 16'hFEDC, '0, '0));
    settle_pipeline();
    apply_settings(MODE_DYNAMIC_ALT, '0, '0, '0, 1'b1, 1'b1, 16'h8000);
    send_particle(make_particle('0, '0, SPD_BOTTOM, 16'h0000, RND_TOP, RND_BOTTOM));
    send_particle(make_particle('0, '0, SPD_TOP, 16'hFFFF, RND_BOTTOM, RND_TOP));
    settle_pipeline();
  endtask

  task automatic test_gain_extremes();
    int i;
    apply_settings(MODE_KINEMATIC, '1, '1, '1, 1'b0, 1'b0, '0);
    for (i = 0; i < GAIN_ITEMS; i++) send_particle(random_particle());
    settle_pipeline();
    apply_settings(MODE_KINEMATIC, '0, '0, '0, 1'b1, 1'b0, '0);
    for (i = 0; i < GAIN_ITEMS; i++) send_particle(random_particle());
    settle_pipeline();
  endtask

  // Random register settings, mostly kinematic, with random particles each
  task automatic test_random_walk();
    int                phase, i;
    logic [MODE_W-1:0] mode;
    for (phase = 0; phase < WALK_PHASES; phase++) begin
      mode = ($urandom_range(0, 9) < 6) ? MODE_KINEMATIC : MODE_W'($urandom_range(1, 3));
      if (phase == 1) mode = MODE_UNUSED;
      apply_settings(mode, pick_gain(), pick_gain(), pick_gain(),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_gain());
      for (i = 0; i < WALK_ITEMS; i++) send_particle(random_particle());
      settle_pipeline();
    end
  endtask

  // Result checking and receiver stall pattern
  always @(posedge clk) begin : result_check
    step_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_steps.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result x=%0d y=%0d speed=%0d heading=%0h",
                     out_new_x, out_new_y, out_new_speed, out_new_heading);
        end else begin
          want = pending_steps.pop_front();
          if (want.x !== out_new_x || want.y !== out_new_y ||
              want.speed !== out_new_speed || want.heading !== out_new_heading) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch: expected x=%0d y=%0d speed=%0d heading=%0h,",
                       want.x, want.y, want.speed, want.heading,
                       " got x=%0d y=%0d speed=%0d heading=%0h",
                       out_new_x, out_new_y, out_new_speed, out_new_heading);
          end
        end
      end
      if (ready_phase_left == 0) begin
        ready_mode       <= ready_pattern_e'($urandom_range(0, 3));
        ready_phase_left <= $urandom_range(40, 240);
      end else begin
        ready_phase_left <= ready_phase_left - 1;
      end
      case (ready_mode)
        RDY_OPEN:  out_ready <= 1'b1;
        RDY_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
        RDY_HEAVY: out_ready <= ($urandom_range(0, 9) < 3);
        default: begin
          if (stall_run != 0) begin
            out_ready <= 1'b0;
            stall_run <= stall_run - 1;
          end else begin
            out_ready <= 1'b1;
            stall_run <= $urandom_range(0, 12);
          end
        end
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_extremes();
    test_register_corners();
    test_gain_extremes();
    test_random_walk();
    settle_pipeline();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
